// ===== sv/wsne_pkg.sv =====
// Package for the weekly schedule next-event block.
// Holds the shared constants, the controller state type and the command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wsne_pkg;

   localparam int DEF_NUM_PERIODS = 4;
   localparam int DEF_NUM_RANGES  = 2;
   localparam int NUM_DAYS        = 7;

   localparam logic [7:0] UNUSED_HOUR = 8'd255;
   localparam logic [7:0] MAX_HOUR    = 8'd23;
   localparam logic [2:0] LAST_DAY    = 3'd6;
   localparam logic [2:0] DAY_MONDAY  = 3'd0;
   localparam logic [2:0] WDAY_NONE   = 3'd0;
   localparam logic [2:0] WDAY_SUNDAY = 3'd1;
   localparam logic [2:0] WDAY_LAST   = 3'd7;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_RD_TODAY,
      ST_EV_TODAY,
      ST_RD_NEXT,
      ST_EV_NEXT,
      ST_FINISH
   } wsne_state_type;

   typedef struct packed {
      logic load_req;
      logic mem_write;
      logic rd_next;
      logic eval_today;
      logic eval_next;
      logic next_period;
      logic load_rsp;
   } wsne_cmd_type;

   typedef struct packed {
      logic is_eval;
      logic wday_zero;
      logic last_period;
      logic need_next;
      logic rsp_free;
   } wsne_status_type;

endpackage

`default_nettype wire

// ===== sv/wsne_req_if.sv =====
// Input channel of the weekly schedule next-event block.
// Carries valid, ready and one request item; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface wsne_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [2:0] day_index;
   logic       range_index;
   logic [1:0] period_index;
   logic [7:0] start_hour;
   logic [7:0] stop_hour;
   logic [4:0] current_hour;
   logic [2:0] current_weekday;

   modport source (
      output valid, command, day_index, range_index, period_index,
             start_hour, stop_hour, current_hour, current_weekday,
      input  ready
   );

   modport sink (
      input  valid, command, day_index, range_index, period_index,
             start_hour, stop_hour, current_hour, current_weekday,
      output ready
   );
endinterface

`default_nettype wire

// ===== sv/wsne_rsp_if.sv =====
// Result channel of the weekly schedule next-event block.
// Carries valid, ready and one result item; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface wsne_rsp_if;
   logic       valid;
   logic       ready;
   logic       event_found;
   logic       next_state;
   logic [4:0] trigger_hour;
   logic [2:0] trigger_weekday;

   modport source (
      output valid, event_found, next_state, trigger_hour, trigger_weekday,
      input  ready
   );

   modport sink (
      input  valid, event_found, next_state, trigger_hour, trigger_weekday,
      output ready
   );
endinterface

`default_nettype wire

// ===== sv/weekly_schedule_next_event.sv =====
// Top level of the weekly schedule next-event block.
// Joins wsne_ctrl and wsne_datapath; uses wsne_pkg, wsne_req_if and wsne_rsp_if.
//
//   Channel   Direction  Transfer condition         Content
//   req_ch    in         req_ch.valid & ready       write entry or evaluate request
//   rsp_ch    out        rsp_ch.valid & ready       one result per request
//   csr_*     in         csr_wr_en high             active schedule range
//
// A write goes from dispatch, where the memory is written, to finish. An evaluation with
// weekday zero goes straight to finish; otherwise it reads and compares each period slot
// in turn, and the next day's entry for each slot whose period is already over; each
// entry costs one registered read of the schedule memory and one compare step.
// The memory is not cleared by reset; only control state and the range register are.
// A waiting result sits in the output register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none

module weekly_schedule_next_event #(
   parameter int NUM_PERIODS = wsne_pkg::DEF_NUM_PERIODS,
   parameter int NUM_RANGES  = wsne_pkg::DEF_NUM_RANGES
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic          csr_wr_data,
   wsne_req_if.sink      req_ch,
   wsne_rsp_if.source    rsp_ch
);
   import wsne_pkg::*;

   wsne_cmd_type    cmd;
   wsne_status_type status;
   logic            req_ready;

   assign req_ch.ready = req_ready;

   wsne_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wsne_datapath #(
      .NUM_PERIODS (NUM_PERIODS),
      .NUM_RANGES  (NUM_RANGES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_command         (req_ch.command),
      .req_day_index       (req_ch.day_index),
      .req_range_index     (req_ch.range_index),
      .req_period_index    (req_ch.period_index),
      .req_start_hour      (req_ch.start_hour),
      .req_stop_hour       (req_ch.stop_hour),
      .req_current_hour    (req_ch.current_hour),
      .req_current_weekday (req_ch.current_weekday),
      .cmd                 (cmd),
      .status              (status),
      .rsp_ready           (rsp_ch.ready),
      .rsp_valid           (rsp_ch.valid),
      .rsp_event_found     (rsp_ch.event_found),
      .rsp_next_state      (rsp_ch.next_state),
      .rsp_trigger_hour    (rsp_ch.trigger_hour),
      .rsp_trigger_weekday (rsp_ch.trigger_weekday)
   );

endmodule

`default_nettype wire

// ===== sv/wsne_ctrl.sv =====
// Controller state machine of the weekly schedule next-event block.
// Sequences writes and the per-period walk; uses wsne_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsne_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  wsne_pkg::wsne_status_type status,
   output wsne_pkg::wsne_cmd_type    cmd
);
   import wsne_pkg::*;

   wsne_state_type state_ff;
   wsne_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (!status.is_eval) begin
               cmd.mem_write = 1'b1;
               state_in      = ST_FINISH;
            end else if (status.wday_zero) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_RD_TODAY;
            end
         end
         ST_RD_TODAY: begin
            state_in = ST_EV_TODAY;
         end
         ST_EV_TODAY: begin
            cmd.eval_today = 1'b1;
            if (status.need_next) begin
               state_in = ST_RD_NEXT;
            end else if (status.last_period) begin
               state_in = ST_FINISH;
            end else begin
               cmd.next_period = 1'b1;
               state_in        = ST_RD_TODAY;
            end
         end
         ST_RD_NEXT: begin
            cmd.rd_next = 1'b1;
            state_in    = ST_EV_NEXT;
         end
         ST_EV_NEXT: begin
            cmd.eval_next = 1'b1;
            if (status.last_period) begin
               state_in = ST_FINISH;
            end else begin
               cmd.next_period = 1'b1;
               state_in        = ST_RD_TODAY;
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/wsne_datapath.sv =====
// Datapath of the weekly schedule next-event block: request latch, schedule memory,
// per-period comparators, running minimums and the result register. Uses wsne_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsne_datapath #(
   parameter int NUM_PERIODS = wsne_pkg::DEF_NUM_PERIODS,
   parameter int NUM_RANGES  = wsne_pkg::DEF_NUM_RANGES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic                      csr_wr_data,
   input  logic                      req_command,
   input  logic [2:0]                req_day_index,
   input  logic                      req_range_index,
   input  logic [1:0]                req_period_index,
   input  logic [7:0]                req_start_hour,
   input  logic [7:0]                req_stop_hour,
   input  logic [4:0]                req_current_hour,
   input  logic [2:0]                req_current_weekday,
   input  wsne_pkg::wsne_cmd_type    cmd,
   output wsne_pkg::wsne_status_type status,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic                      rsp_event_found,
   output logic                      rsp_next_state,
   output logic [4:0]                rsp_trigger_hour,
   output logic [2:0]                rsp_trigger_weekday
);
   import wsne_pkg::*;

   localparam int DEPTH    = NUM_DAYS * NUM_RANGES * NUM_PERIODS;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int PERIOD_W = (NUM_PERIODS > 1) ? $clog2(NUM_PERIODS) : 1;
   localparam int RANGE_W  = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
   localparam logic [ADDR_W-1:0]   NR_A     = ADDR_W'(NUM_RANGES);
   localparam logic [ADDR_W-1:0]   NP_A     = ADDR_W'(NUM_PERIODS);
   localparam logic [PERIOD_W-1:0] LAST_P   = PERIOD_W'(NUM_PERIODS - 1);
   localparam logic [RANGE_W-1:0]  LAST_R   = RANGE_W'(NUM_RANGES - 1);

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [ADDR_W-1:0] d,
                                                  input logic [ADDR_W-1:0] r,
                                                  input logic [ADDR_W-1:0] p);
      logic [ADDR_W-1:0] row;
      row = d * NR_A + r;
      return row * NP_A + p;
   endfunction

   logic [15:0] sched_mem_ff [DEPTH];
   logic [15:0] rdata_ff;

   logic          active_range_ff;
   logic          cmd_ff;
   logic [2:0]    day_ff;
   logic          range_idx_ff;
   logic [1:0]    period_idx_ff;
   logic [7:0]    start_ff;
   logic [7:0]    stop_ff;
   logic [4:0]    hour_ff;
   logic [2:0]    wday_ff;
   logic [PERIOD_W-1:0] period_cnt_ff;
   logic [PERIOD_W-1:0] period_cnt_in;

   logic       have_off_ff, have_on_ff, have_next_ff;
   logic       have_off_in, have_on_in, have_next_in;
   logic [4:0] best_off_ff, best_on_ff, best_next_ff;
   logic [4:0] best_off_in, best_on_in, best_next_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_found_ff, rsp_found_in;
   logic       rsp_state_ff, rsp_state_in;
   logic [4:0] rsp_hour_ff, rsp_hour_in;
   logic [2:0] rsp_wday_ff, rsp_wday_in;

   logic [RANGE_W-1:0] range_sel;
   logic [2:0]         today;
   logic [2:0]         tomorrow;
   logic [2:0]         next_wday;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  wr_addr;
   logic               wr_ok;
   logic [7:0]         e_start;
   logic [7:0]         e_stop;
   logic [7:0]         hour8;
   logic               e_unused;
   logic               e_before;
   logic               e_running;
   logic               start_ok;
   logic               stop_ok;

   always_comb begin
      range_sel = (32'(active_range_ff) < NUM_RANGES) ? RANGE_W'(active_range_ff) : LAST_R;
      today     = (wday_ff == WDAY_SUNDAY) ? LAST_DAY : wday_ff - 3'd2;
      tomorrow  = (today == LAST_DAY) ? DAY_MONDAY : today + 3'd1;
      next_wday = (wday_ff == WDAY_LAST) ? WDAY_SUNDAY : wday_ff + 3'd1;
      rd_addr   = slot_addr(ADDR_W'(cmd.rd_next ? tomorrow : today), ADDR_W'(range_sel),
                            ADDR_W'(period_cnt_ff));
      wr_addr   = slot_addr(ADDR_W'(day_ff), ADDR_W'(range_idx_ff), ADDR_W'(period_idx_ff));
      wr_ok     = (day_ff <= LAST_DAY) && (32'(range_idx_ff) < NUM_RANGES)
                  && (32'(period_idx_ff) < NUM_PERIODS);
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_write && wr_ok) begin
         sched_mem_ff[wr_addr] <= {start_ff, stop_ff};
      end
      rdata_ff <= sched_mem_ff[rd_addr];
   end

   always_comb begin
      e_start   = rdata_ff[15:8];
      e_stop    = rdata_ff[7:0];
      hour8     = {3'b000, hour_ff};
      e_unused  = (e_start == UNUSED_HOUR) && (e_stop == UNUSED_HOUR);
      e_before  = !e_unused && (hour8 < e_start);
      e_running = !e_unused && !(hour8 < e_start) && (hour8 < e_stop);
      start_ok  = e_start <= MAX_HOUR;
      stop_ok   = e_stop <= MAX_HOUR;
   end

   always_comb begin
      have_off_in   = have_off_ff;
      have_on_in    = have_on_ff;
      have_next_in  = have_next_ff;
      best_off_in   = best_off_ff;
      best_on_in    = best_on_ff;
      best_next_in  = best_next_ff;
      period_cnt_in = period_cnt_ff;
      if (cmd.load_req) begin
         have_off_in   = 1'b0;
         have_on_in    = 1'b0;
         have_next_in  = 1'b0;
         period_cnt_in = '0;
      end
      if (cmd.next_period) begin
         period_cnt_in = period_cnt_ff + 1'b1;
      end
      if (cmd.eval_today) begin
         if (e_before && start_ok && (!have_on_ff || e_start[4:0] < best_on_ff)) begin
            have_on_in = 1'b1;
            best_on_in = e_start[4:0];
         end
         if (e_running && stop_ok && (!have_off_ff || e_stop[4:0] < best_off_ff)) begin
            have_off_in = 1'b1;
            best_off_in = e_stop[4:0];
         end
      end
      if (cmd.eval_next) begin
         if (!e_unused && start_ok && (!have_next_ff || e_start[4:0] < best_next_ff)) begin
            have_next_in = 1'b1;
            best_next_in = e_start[4:0];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_state_in = rsp_state_ff;
      rsp_hour_in  = rsp_hour_ff;
      rsp_wday_in  = rsp_wday_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = 1'b0;
         rsp_state_in = 1'b0;
         rsp_hour_in  = '0;
         rsp_wday_in  = '0;
         if (have_off_ff) begin
            rsp_found_in = 1'b1;
            rsp_hour_in  = best_off_ff;
            rsp_wday_in  = wday_ff;
         end else if (have_on_ff) begin
            rsp_found_in = 1'b1;
            rsp_state_in = 1'b1;
            rsp_hour_in  = best_on_ff;
            rsp_wday_in  = wday_ff;
         end else if (have_next_ff) begin
            rsp_found_in = 1'b1;
            rsp_state_in = 1'b1;
            rsp_hour_in  = best_next_ff;
            rsp_wday_in  = next_wday;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_range_ff <= 1'b0;
         have_off_ff     <= 1'b0;
         have_on_ff      <= 1'b0;
         have_next_ff    <= 1'b0;
         period_cnt_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            active_range_ff <= csr_wr_data;
         end
         have_off_ff   <= have_off_in;
         have_on_ff    <= have_on_in;
         have_next_ff  <= have_next_in;
         period_cnt_ff <= period_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff        <= req_command;
         day_ff        <= req_day_index;
         range_idx_ff  <= req_range_index;
         period_idx_ff <= req_period_index;
         start_ff      <= req_start_hour;
         stop_ff       <= req_stop_hour;
         hour_ff       <= req_current_hour;
         wday_ff       <= req_current_weekday;
      end
      best_off_ff  <= best_off_in;
      best_on_ff   <= best_on_in;
      best_next_ff <= best_next_in;
      rsp_found_ff <= rsp_found_in;
      rsp_state_ff <= rsp_state_in;
      rsp_hour_ff  <= rsp_hour_in;
      rsp_wday_ff  <= rsp_wday_in;
   end

   always_comb begin
      status.is_eval     = cmd_ff == CMD_EVAL;
      status.wday_zero   = wday_ff == WDAY_NONE;
      status.last_period = period_cnt_ff == LAST_P;
      status.need_next   = !e_unused && !(hour8 < e_start) && !(hour8 < e_stop);
      status.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_found     = rsp_found_ff;
   assign rsp_next_state      = rsp_state_ff;
   assign rsp_trigger_hour    = rsp_hour_ff;
   assign rsp_trigger_weekday = rsp_wday_ff;

endmodule

`default_nettype wire
